// File: design/first_fit_heap_allocator_top_defines.svh
// Assertion macros for the first-fit heap allocator checker
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
// Implication checked on every rising edge outside reset
`define FFH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffh check failed");
// Next-cycle implication outside reset
`define FFH_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffh check failed");
`endif

// File: design/ffh_pkg.sv
// Package for the first-fit heap allocator: types, constants and codes
package ffh_pkg;
    localparam int MAX_BLOCKS_DEF   = 256;
    localparam int HEADER_BYTES_DEF = 8;
    localparam logic [47:0] HEAP_OFFSET = 48'h1000;
    localparam logic [24:0] PAD_BYTES   = 25'd4;
    localparam logic [24:0] HEAP_BYTES_RESET = 25'h1000000;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_NO_MEMORY = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_UNKNOWN   = 3'd4
    } status_t;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_HEAP_START = 1'b0,
        REG_HEAP_BYTES = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_APPEND,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        opcode;
        logic [23:0] request_bytes;
        logic [47:0] release_address;
    } ffh_in_t;

    typedef struct packed {
        logic [47:0] data_address;
        logic [2:0]  status;
        logic [24:0] used_bytes;
        logic [24:0] free_bytes;
    } ffh_out_t;
endpackage

// File: design/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: block table walk and bookkeeping
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall  | ffh_in_t
//  out     | output    | out_valid/out_stall| ffh_out_t
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// Each record walked passes through S_READ, which addresses the record memory, and S_CHECK,
// which sees its registered read. A match, an unknown release and an append attempt (through
// S_APPEND) end in S_DONE; a zero size goes from S_READ straight to S_DONE.
// One item is in work at a time; a finished result waits in the output register, and the
// next item is taken the cycle after it leaves.
// Reset or a configuration write restarts the heap by zeroing the block count.
module first_fit_heap_allocator_top
    import ffh_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  ffh_in_t    in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output ffh_out_t   out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [47:0] cfg_data
);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [24:0] HDR = 25'(HEADER_BYTES);

    // Block record memory: {taken, length}
    logic [24:0] mem [MAX_BLOCKS];
    logic [24:0] rd_data_reg;
    logic        mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [24:0] mem_wdata;

    state_t state_reg, state_next;
    logic [47:0] heap_start_reg;
    logic [24:0] heap_bytes_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [48:0] bump_reg, bump_next;
    logic [24:0] used_reg, used_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [48:0] addr_reg, addr_next;
    ffh_in_t     req_reg;
    logic        out_valid_reg, out_valid_next;
    ffh_out_t    out_reg, out_next;

    logic [25:0] sum_used;
    logic [24:0] rel_dec;
    logic [49:0] need_end, region_end;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            heap_start_reg <= '0;
            heap_bytes_reg <= HEAP_BYTES_RESET;
            count_reg      <= '0;
            bump_reg       <= {1'b0, HEAP_OFFSET};
            used_reg       <= '0;
            idx_reg        <= '0;
            addr_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            bump_reg      <= bump_next;
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            // Restart the heap on a configuration write
            if (cfg_valid && cfg_ready)
            begin
                if (reg_index_t'(cfg_index) == REG_HEAP_START)
                begin
                    heap_start_reg <= cfg_data;
                    bump_reg       <= {1'b0, cfg_data} + {1'b0, HEAP_OFFSET};
                end
                else
                begin
                    heap_bytes_reg <= cfg_data[24:0];
                    bump_reg       <= {1'b0, heap_start_reg} + {1'b0, HEAP_OFFSET};
                end
                count_reg <= '0;
                used_reg  <= '0;
            end
        end
    end

    // Hold the request and the result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg <= in_data;
        end
        out_reg <= out_next;
    end

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign rel_dec  = rd_data_reg[23:0] + HDR;
    assign sum_used = {1'b0, used_reg} + {2'b0, req_reg.request_bytes} + {1'b0, HDR};
    assign need_end = {1'b0, bump_reg} + {26'b0, req_reg.request_bytes} + {25'b0, HDR};
    assign region_end = {2'b0, heap_start_reg} + {2'b0, HEAP_OFFSET}
                      + {25'b0, heap_bytes_reg};

    // Sequence the table walk and result
    always_comb
    begin
        logic [26:0] s27;
        state_next     = state_reg;
        count_next     = count_reg;
        bump_next      = bump_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[IW-1:0];
        mem_raddr      = idx_reg[IW-1:0];
        mem_wdata      = '0;
        s27            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    idx_next   = '0;
                    addr_next  = {1'b0, heap_start_reg} + {1'b0, HEAP_OFFSET};
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                out_next.data_address = '0;
                out_next.status       = ST_OK;
                if (opcode_t'(req_reg.opcode) == OP_ALLOC && req_reg.request_bytes == '0)
                begin
                    out_next.status = ST_ZERO_SIZE;
                    state_next      = S_DONE;
                end
                else if (idx_reg == count_reg)
                begin
                    if (opcode_t'(req_reg.opcode) == OP_RELEASE)
                    begin
                        out_next.status = ST_UNKNOWN;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                mem_waddr = idx_reg[IW-1:0];
                if (opcode_t'(req_reg.opcode) == OP_ALLOC)
                begin
                    if (!rd_data_reg[24] && rd_data_reg[23:0] >= req_reg.request_bytes)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {1'b1, rd_data_reg[23:0]};
                        used_next = sum_used[25] ? '1 : sum_used[24:0];
                        out_next.data_address = 48'(addr_reg + {24'b0, HDR});
                        state_next = S_DONE;
                    end
                end
                else if (48'(addr_reg + {24'b0, HDR}) == req_reg.release_address)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b0, rd_data_reg[23:0]};
                    used_next = (used_reg > rel_dec) ? used_reg - rel_dec : '0;
                    state_next = S_DONE;
                end
                if (state_next == S_CHECK)
                begin
                    addr_next  = addr_reg + {25'b0, rd_data_reg[23:0]} + {24'b0, HDR}
                               + {24'b0, PAD_BYTES};
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_APPEND:
            begin
                if (need_end >= region_end)
                begin
                    out_next.status = ST_NO_MEMORY;
                end
                else if (count_reg == CW'(MAX_BLOCKS))
                begin
                    out_next.status = ST_TABLE_FULL;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = count_reg[IW-1:0];
                    mem_wdata = {1'b1, req_reg.request_bytes};
                    count_next = count_reg + 1'b1;
                    out_next.data_address = 48'(bump_reg + {24'b0, HDR});
                    bump_next = 49'(need_end + {25'b0, PAD_BYTES});
                    s27 = {2'b0, used_reg} + {3'b0, req_reg.request_bytes} + {2'b0, HDR}
                        + {2'b0, PAD_BYTES};
                    used_next = (s27 > 27'h1FFFFFF) ? '1 : s27[24:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_next.used_bytes = used_reg;
                out_next.free_bytes = (heap_bytes_reg > used_reg) ?
                                      heap_bytes_reg - used_reg : '0;
                out_valid_next      = 1'b1;
                state_next          = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// File: design/ffh_checker.sv
// Port-level checker for the first-fit heap allocator, bound to the top level
`include "first_fit_heap_allocator_top_defines.svh"
module ffh_checker
    import ffh_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input ffh_out_t out_data,
    input logic     cfg_ready
);
    `FFH_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `FFH_ASSERT_IMP(a_status_range, out_valid, out_data.status <= ST_UNKNOWN)
    `FFH_ASSERT_IMP(a_fail_zero, out_valid && out_data.status != ST_OK, out_data.data_address == '0)
    `FFH_ASSERT_NXT(a_one_item, in_valid && !in_stall, in_stall && !cfg_ready)
endmodule

bind first_fit_heap_allocator_top ffh_checker u_ffh_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_ready(cfg_ready)
);

// File: test/tb.sv
// Self-checking testbench for the first-fit heap allocator top level
module tb;
    import ffh_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int HDR_BYTES   = 8;
    localparam int STALL_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    ffh_in_t    in_data;
    logic       out_valid;
    logic       out_stall;
    ffh_out_t   out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [47:0] cfg_data;

    // Predicted allocator state
    logic [23:0] blk_len [TABLE_DEPTH];
    bit          blk_taken [TABLE_DEPTH];
    int          blk_count;
    logic [63:0] bump_addr;
    logic [63:0] in_use;
    logic [63:0] base_addr;
    logic [63:0] heap_len;

    ffh_out_t    pending_results[$];
    logic [47:0] granted_addrs[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          idle_cycles;
    bit          failed;

    first_fit_heap_allocator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Clear the predicted heap after reset or a register write
    task automatic restart_model();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            blk_len[i]   = '0;
            blk_taken[i] = 1'b0;
        end
        blk_count = 0;
        in_use    = '0;
        bump_addr = base_addr + 64'h1000;
        granted_addrs.delete();
    endtask

    // Advance the predicted state by one transaction and queue its result
    task automatic predict_item(input ffh_in_t it);
        ffh_out_t    r;
        logic [63:0] addr;
        logic [63:0] dec;
        logic [63:0] sum;
        bit          found;
        r      = '0;
        addr   = base_addr + 64'h1000;
        found  = 1'b0;
        if (it.opcode == OP_ALLOC)
        begin
            if (it.request_bytes == 0)
                r.status = ST_ZERO_SIZE;
            else
            begin
                for (int i = 0; i < blk_count && !found; i++)
                begin
                    if (!blk_taken[i] && blk_len[i] >= it.request_bytes)
                    begin
                        blk_taken[i] = 1'b1;
                        sum = in_use + it.request_bytes + HDR_BYTES;
                        in_use = (sum > 64'h1FFFFFF) ? 64'h1FFFFFF : sum;
                        r.data_address = addr[47:0] + 48'(HDR_BYTES);
                        found = 1'b1;
                    end
                    else
                        addr = addr + blk_len[i] + HDR_BYTES + 4;
                end
                if (!found)
                begin
                    if (bump_addr + it.request_bytes + HDR_BYTES >=
                        base_addr + 64'h1000 + heap_len)
                        r.status = ST_NO_MEMORY;
                    else if (blk_count >= TABLE_DEPTH)
                        r.status = ST_TABLE_FULL;
                    else
                    begin
                        blk_len[blk_count]   = it.request_bytes;
                        blk_taken[blk_count] = 1'b1;
                        blk_count++;
                        r.data_address = bump_addr[47:0] + 48'(HDR_BYTES);
                        bump_addr = bump_addr + it.request_bytes + HDR_BYTES + 4;
                        sum = in_use + it.request_bytes + HDR_BYTES + 4;
                        in_use = (sum > 64'h1FFFFFF) ? 64'h1FFFFFF : sum;
                    end
                end
                if (r.status == ST_OK)
                    granted_addrs.push_back(r.data_address);
            end
        end
        else
        begin
            for (int i = 0; i < blk_count && !found; i++)
            begin
                if (addr[47:0] + 48'(HDR_BYTES) == it.release_address)
                begin
                    dec = blk_len[i] + HDR_BYTES;
                    blk_taken[i] = 1'b0;
                    in_use = (in_use > dec) ? in_use - dec : 64'd0;
                    found = 1'b1;
                end
                else
                    addr = addr + blk_len[i] + HDR_BYTES + 4;
            end
            if (!found)
                r.status = ST_UNKNOWN;
        end
        r.used_bytes = in_use[24:0];
        r.free_bytes = (heap_len > in_use) ? 25'(heap_len - in_use) : 25'd0;
        pending_results.push_back(r);
    endtask

    // Offer one transaction, idling beforehand at random, and hold until taken
    task automatic send_item(input ffh_in_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            in_data  <= ffh_in_t'(73'({$urandom, $urandom, $urandom}));
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item(it);
    endtask

    task automatic send_alloc(input logic [23:0] nbytes);
        ffh_in_t it;
        it.opcode          = OP_ALLOC;
        it.request_bytes   = nbytes;
        it.release_address = 48'({$urandom, $urandom});
        send_item(it);
    endtask

    task automatic send_release(input logic [47:0] addr);
        ffh_in_t it;
        it.opcode          = OP_RELEASE;
        it.request_bytes   = 24'($urandom);
        it.release_address = addr;
        send_item(it);
    endtask

    // Drop the request line and wait for every result to leave the block
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input reg_index_t idx, input logic [47:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_HEAP_START)
            base_addr = {16'd0, value};
        else
            heap_len = {39'd0, value[24:0]};
        restart_model();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Zero size, oversize, reuse without split, unknown and double release
    task automatic test_directed();
        logic [47:0] first_addr;
        logic [47:0] big_addr;
        write_reg(REG_HEAP_START, 48'd0);
        write_reg(REG_HEAP_BYTES, 48'h1000000);
        send_alloc(24'd0);
        send_alloc(24'd1);
        first_addr = granted_addrs[$];
        send_alloc(24'hFFFFFF);
        send_alloc(24'h800000);
        big_addr = granted_addrs[$];
        send_release(48'hFFFF_FFFF_FFFF);
        send_release(48'h0);
        send_release(big_addr);
        send_alloc(24'd5);
        send_release(first_addr);
        send_release(first_addr);
        send_alloc(24'h7FFFFF);
        send_release(big_addr);
        send_release(big_addr);
        // Tiny heap: second request crosses the end
        write_reg(REG_HEAP_BYTES, 48'd100);
        send_alloc(24'd80);
        send_alloc(24'd20);
        send_alloc(24'd7);
        // Empty heap
        write_reg(REG_HEAP_BYTES, 48'd0);
        send_alloc(24'd1);
        send_release(48'h1008);
        // Heap at the top of the address space: data addresses wrap
        write_reg(REG_HEAP_START, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_HEAP_BYTES, 48'h1000000);
        send_alloc(24'd3);
        send_alloc(24'h555555);
        send_release(granted_addrs[0]);
        send_alloc(24'hAAAAAA);
    endtask

    // Fill every block record, then probe the full table
    task automatic test_table_full();
        logic [47:0] victim;
        write_reg(REG_HEAP_START, 48'd0);
        write_reg(REG_HEAP_BYTES, 48'h1000000);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_alloc(24'(1 + (i % 4)));
        send_alloc(24'd1);
        victim = granted_addrs[3];
        send_release(victim);
        send_alloc(24'd9);
        send_alloc(24'd2);
        send_release(granted_addrs[$]);
        send_release(48'hFFFF_FFFF_FFFF);
    endtask

    // Mostly allocate and release of granted addresses, with some noise
    task automatic test_random(input int send_pct, input int recv_pct, input int count);
        int          sel;
        logic [23:0] nbytes;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
            begin
                write_reg(REG_HEAP_START, 48'({$urandom, $urandom}));
                sel = $urandom_range(3);
                write_reg(REG_HEAP_BYTES, sel == 0 ? 48'd3000 :
                          sel == 1 ? 48'h1000000 : 48'($urandom_range(25'h1000000)));
            end
            sel = $urandom_range(99);
            if (sel < 55)
            begin
                nbytes = ($urandom_range(19) == 0) ? 24'($urandom) :
                         24'($urandom_range(64));
                send_alloc(nbytes);
            end
            else if (sel < 93 && granted_addrs.size() != 0)
                send_release(granted_addrs[$urandom_range(granted_addrs.size() - 1)]);
            else
                send_release(48'({$urandom, $urandom}));
        end
    endtask

    // Receiver stalls at random; watchdog on accepted transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        ffh_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result %h", out_data);
                failed = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.data_address !== want.data_address)
                begin
                    $error("data_address expected %h actual %h",
                           want.data_address, out_data.data_address);
                    failed = 1'b1;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, out_data.status);
                    failed = 1'b1;
                end
                if (out_data.used_bytes !== want.used_bytes)
                begin
                    $error("used_bytes expected %0d actual %0d",
                           want.used_bytes, out_data.used_bytes);
                    failed = 1'b1;
                end
                if (out_data.free_bytes !== want.free_bytes)
                begin
                    $error("free_bytes expected %0d actual %0d",
                           want.free_bytes, out_data.free_bytes);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        failed        = 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 59;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_HEAP_START;
        cfg_data      = '0;
        base_addr     = '0;
        heap_len      = 64'h1000000;
        restart_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_random(11, 59, 220);
        test_random(59, 11, 220);
        test_random(0, 0, 220);
        drain();
        repeat (600) @(posedge clk);
        if (!failed && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
